// File: sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the streaming base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned AccW   = 12;
  localparam int unsigned PendW  = 3;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] CapacityReset = 16'hFFFF;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            terminator;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              finished;
    logic              decode_error;
    logic [CountW-1:0] total_bytes;
  } out_beat_t;

  // classification of one input character
  typedef struct packed {
    logic             ok;     // base64 alphabet member
    logic             skip;   // padding or whitespace
    logic [SextW-1:0] value;
  } sym_info_t;

endpackage

// File: sv/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character per beat in, one result per beat
// out.
// ----------------------------------------------------------------------------
// Takes one character every clock and gives exactly one result beat per input
// beat, in the cycle after acceptance, from a single output register; a full
// cycle rate is kept as long as the output side drains it. Padding, CR, LF
// and space are skipped; any other non-alphabet character, or a byte past
// cfg_wdata's capacity, sets a sticky error until the terminator beat, which
// reports the byte count or the error and clears the string state. Capacity
// resets to 65535 and should be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  b64d_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output b64d_pkg::out_beat_t         out_data,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::CountW-1:0] cfg_wdata
);
  import b64d_pkg::*;

  logic              in_take;
  logic [CountW-1:0] cap_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  sym_info_t         info;
  out_beat_t         result;

  assign in_stall  = out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  b64d_sextet u_sextet (
    .symbol (in_data.symbol),
    .info   (info)
  );

  b64d_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (in_take),
    .beat     (in_data),
    .info     (info),
    .capacity (cap_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapacityReset;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= result;
    end
  end

endmodule

// File: sv/b64d_sextet.sv
// ----------------------------------------------------------------------------
// b64d_sextet
// Maps one ASCII character to its six-bit base64 value and flags characters
// that are skipped or invalid.
// ----------------------------------------------------------------------------
module b64d_sextet (
  input  logic [b64d_pkg::SymW-1:0] symbol,
  output b64d_pkg::sym_info_t       info
);
  import b64d_pkg::*;

  localparam logic [SymW-1:0] ChUpA  = 8'h41;
  localparam logic [SymW-1:0] ChUpZ  = 8'h5A;
  localparam logic [SymW-1:0] ChLoA  = 8'h61;
  localparam logic [SymW-1:0] ChLoZ  = 8'h7A;
  localparam logic [SymW-1:0] ChDig0 = 8'h30;
  localparam logic [SymW-1:0] ChDig9 = 8'h39;
  localparam logic [SymW-1:0] ChPlus = 8'h2B;
  localparam logic [SymW-1:0] ChSlsh = 8'h2F;
  localparam logic [SymW-1:0] ChPad  = 8'h3D;
  localparam logic [SymW-1:0] ChCr   = 8'h0D;
  localparam logic [SymW-1:0] ChLf   = 8'h0A;
  localparam logic [SymW-1:0] ChSpc  = 8'h20;

  localparam logic [SymW-1:0] OffLo  = 8'd71;  // 'a' - 26
  localparam logic [SymW-1:0] OffDig = 8'd4;   // 52 - '0'

  logic [SymW-1:0] diff;

  always_comb begin
    info = '0;
    diff = '0;
    if (symbol >= ChUpA && symbol <= ChUpZ) begin
      diff       = symbol - ChUpA;
      info.ok    = 1'b1;
      info.value = diff[SextW-1:0];
    end else if (symbol >= ChLoA && symbol <= ChLoZ) begin
      diff       = symbol - OffLo;
      info.ok    = 1'b1;
      info.value = diff[SextW-1:0];
    end else if (symbol >= ChDig0 && symbol <= ChDig9) begin
      diff       = symbol + OffDig;
      info.ok    = 1'b1;
      info.value = diff[SextW-1:0];
    end else if (symbol == ChPlus) begin
      info.ok    = 1'b1;
      info.value = 6'd62;
    end else if (symbol == ChSlsh) begin
      info.ok    = 1'b1;
      info.value = 6'd63;
    end else if (symbol == ChPad || symbol == ChCr || symbol == ChLf || symbol == ChSpc) begin
      info.skip  = 1'b1;
    end
  end

endmodule

// File: sv/b64d_step.sv
// ----------------------------------------------------------------------------
// b64d_step
// Per-string decode state: bit accumulator, pending bit count, byte count
// and sticky error. Forms the result of each beat and advances the state.
// ----------------------------------------------------------------------------
module b64d_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  b64d_pkg::in_beat_t          beat,
  input  b64d_pkg::sym_info_t         info,
  input  logic [b64d_pkg::CountW-1:0] capacity,
  output b64d_pkg::out_beat_t         result
);
  import b64d_pkg::*;

  logic [AccW-1:0]   acc_r, acc_nxt;
  logic [PendW-1:0]  pend_r, pend_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic              err_r, err_nxt;

  logic [AccW-1:0]   acc_sh;
  logic [PendW:0]    pend_sum;
  logic [PendW:0]    pend_left;

  always_comb begin
    result    = '0;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    acc_sh    = {acc_r[AccW-SextW-1:0], info.value};
    pend_sum  = {1'b0, pend_r} + 4'd6;
    pend_left = pend_sum - 4'd8;
    if (beat.terminator) begin
      result.finished     = 1'b1;
      result.decode_error = err_r;
      result.total_bytes  = err_r ? '0 : cnt_r;
      acc_nxt  = '0;
      pend_nxt = '0;
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
    end else if (!err_r && !info.skip) begin
      if (!info.ok) begin
        err_nxt = 1'b1;
      end else begin
        acc_nxt = acc_sh;
        if (pend_sum[PendW]) begin
          pend_nxt = pend_left[PendW-1:0];
          if (cnt_r >= capacity) begin
            err_nxt = 1'b1;
          end else begin
            result.out_byte   = 8'(acc_sh >> pend_left[PendW-1:0]);
            result.byte_valid = 1'b1;
            cnt_nxt           = cnt_r + 16'd1;
          end
        end else begin
          pend_nxt = pend_sum[PendW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      err_r  <= 1'b0;
    end else if (advance) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// File: sv/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 decoder core.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input b64d_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input b64d_pkg::out_beat_t out_data
);
  import b64d_pkg::*;

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_term_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.terminator |=> out_valid && out_data.finished)
    else $error("terminator beat did not give a finished result");

  a_no_status_midstring : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.finished |->
      out_data.decode_error == 1'b0 && out_data.total_bytes == '0)
    else $error("status fields set without finished");

  a_byte_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
    else $error("byte present without byte_valid");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/b64d_tb_pkg.sv
// ----------------------------------------------------------------------------
// b64d_tb_pkg
// Decode predictor and result scoreboard for the base64 stream decoder bench.
// ----------------------------------------------------------------------------
package b64d_tb_pkg;

  import b64d_pkg::*;

  class b64_decode_predictor;

    logic [CountW-1:0] capacity;
    logic [AccW-1:0]   bit_store;
    int unsigned       bits_held;
    logic [CountW-1:0] bytes_done;
    bit                sticky_err;
    out_beat_t         due_results[$];
    int unsigned       fail_count;

    function new();
      capacity   = CapacityReset;
      fail_count = 0;
      clear_string();
    endfunction

    function void clear_string();
      bit_store  = '0;
      bits_held  = 0;
      bytes_done = '0;
      sticky_err = 1'b0;
    endfunction

    // -1 for anything outside the alphabet
    function int char_to_sextet(logic [SymW-1:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
    endfunction

    function bit is_skipped(logic [SymW-1:0] c);
      return c == "=" || c == 8'h0D || c == 8'h0A || c == " ";
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    function void note_beat(in_beat_t beat);
      out_beat_t res;
      int        sx;
      res = '0;
      if (beat.terminator) begin
        res.finished     = 1'b1;
        res.decode_error = sticky_err;
        res.total_bytes  = sticky_err ? '0 : bytes_done;
        clear_string();
      end else if (!sticky_err && !is_skipped(beat.symbol)) begin
        sx = char_to_sextet(beat.symbol);
        if (sx < 0) begin
          sticky_err = 1'b1;
        end else begin
          bit_store = {bit_store[5:0], 6'(sx)};
          bits_held += 6;
          if (bits_held >= 8) begin
            bits_held -= 8;
            if (bytes_done >= capacity) begin
              sticky_err = 1'b1;
            end else begin
              res.out_byte   = 8'(bit_store >> bits_held);
              res.byte_valid = 1'b1;
              bytes_done     = bytes_done + 1'b1;
            end
          end
        end
      end
      due_results.push_back(res);
    endfunction

    function void report(string what, out_beat_t want, out_beat_t got);
      string want_s;
      string got_s;
      want_s = $sformatf("byte=%02h bv=%0b fin=%0b err=%0b total=%0d",
                         want.out_byte, want.byte_valid, want.finished,
                         want.decode_error, want.total_bytes);
      got_s  = $sformatf("byte=%02h bv=%0b fin=%0b err=%0b total=%0d",
                         got.out_byte, got.byte_valid, got.finished,
                         got.decode_error, got.total_bytes);
      if (fail_count < 10)
        $display("%0t: %s: expected %s, got %s", $time, what, want_s, got_s);
      fail_count++;
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (due_results.size() == 0) begin
        report("result beat with nothing due", '0, got);
        return;
      end
      want = due_results.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.finished !== want.finished || got.decode_error !== want.decode_error ||
          got.total_bytes !== want.total_bytes)
        report("result mismatch", want, got);
    endfunction

  endclass

endpackage

// File: tb/sv/tb_base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_core
// Drives character beats and terminators through the decoder under random
// idling and output stalls, predicts every result beat and checks it in order.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_core;

  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;
  import b64d_tb_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_beat_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;

  b64_decode_predictor predictor = new();

  bit          quiet      = 1'b0;
  bit          idle_on    = 1'b0;
  int unsigned beat_count = 0;

  base64_stream_decoder_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("base64_stream_decoder_core test failed");
    $finish;
  end

  // results first: a beat accepted on this edge cannot yet have a result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) predictor.check_beat(out_data);
      if (in_valid && !in_stall) predictor.note_beat(in_data);
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if (!quiet && $urandom_range(0, 3) != 0) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [7:0] sextet_char(int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] skip_char();
    case ($urandom_range(0, 3))
      0: return 8'("=");
      1: return 8'h0D;
      2: return 8'h0A;
      default: return 8'(" ");
    endcase
  endfunction

  task automatic send_beat(in_beat_t beat);
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beat_count++;
  endtask

  task automatic put_symbol(logic [7:0] c);
    send_beat('{symbol: c, terminator: 1'b0});
  endtask

  task automatic put_end();
    send_beat('{symbol: 8'($urandom_range(0, 255)), terminator: 1'b1});
  endtask

  task automatic put_text(string s);
    foreach (s[i]) put_symbol(s[i]);
    put_end();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CountW-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    predictor.capacity = cap;
  endtask

  task automatic send_string();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
    if ($urandom_range(0, 9) == 0) begin
      repeat (n) put_symbol(8'($urandom_range(0, 255)));
    end else begin
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) put_symbol(skip_char());
        if ($urandom_range(0, 19) == 0) put_symbol(8'($urandom_range(0, 255)));
        put_symbol(sextet_char($urandom_range(0, 63)));
      end
      repeat ($urandom_range(0, 2)) put_symbol(8'("="));
    end
    put_end();
  endtask

  initial begin
    logic [CountW-1:0] caps[8];
    int unsigned       budget;

    caps = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd7,
             16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)), 16'hFFFF};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // capacity still at its reset value
    put_text("TWFu");
    put_text("AZaz09+/");
    put_text("Q =\r\nQ");
    put_symbol(8'("Q"));
    put_symbol(8'h00);
    put_text("Q");
    put_symbol(8'hFF);
    put_end();
    put_text("@A");

    set_capacity(16'd0);
    put_text("AA");
    set_capacity(16'd1);
    put_text("AAA");

    foreach (caps[p]) begin
      set_capacity(caps[p]);
      if (p == 7) quiet = 1'b1;
      budget = beat_count + 175;
      while (beat_count < budget) begin
        idle_on = ($urandom_range(0, 2) != 0);
        send_string();
      end
    end

    drain();
    if (predictor.fail_count == 0 && predictor.outstanding() == 0) begin
      $display("base64_stream_decoder_core test passed");
    end else begin
      $display("base64_stream_decoder_core test failed");
    end
    $finish;
  end

endmodule
